// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands. They compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted (active low).
`define HMAF_ASSERT_IMP(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error("histogram finder: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define HMAF_ASSERT_NXT(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error("histogram finder: next-cycle check failed");

`else

`define HMAF_ASSERT_IMP(label, clk, rstn, cond, prop)
`define HMAF_ASSERT_NXT(label, clk, rstn, cond, prop)

`endif

`endif

// File: design/hmaf_pkg.sv
// ----------------------------------------------------------------------------
// hmaf_pkg
// Shared widths, payload types and control codes of the histogram finder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hmaf_pkg;

    localparam int KEY_BITS    = 8;
    localparam int COUNT_BITS  = 11;
    localparam int NUM_BINS    = 1 << KEY_BITS;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef logic [KEY_BITS-1:0]   bin_addr_t;
    typedef logic [COUNT_BITS-1:0] count_t;

    typedef struct packed {
        logic signed [KEY_BITS-1:0] key_value;
        logic                       is_last;
    } in_item_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0]      top_count;
        logic signed [KEY_BITS-1:0] top_key_small;
        logic signed [KEY_BITS-1:0] top_key_large;
        logic [COUNT_BITS-1:0]      low_count;
        logic signed [KEY_BITS-1:0] low_key_small;
        logic signed [KEY_BITS-1:0] low_key_large;
        logic                       count_saturated;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_COUNT,
        ST_SCAN
    } back_state_t;

endpackage

// File: design/hmaf_ram.sv
// ----------------------------------------------------------------------------
// hmaf_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hmaf_ram #(
    parameter int DATA_BITS = 8,
    parameter int ADDR_BITS = 8
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [DATA_BITS-1:0] rd_data
);

    logic [DATA_BITS-1:0] mem_reg [2**ADDR_BITS];
    logic [DATA_BITS-1:0] rd_data_reg;

    // A read of the address being written returns the old contents.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/hmaf_front.sv
// ----------------------------------------------------------------------------
// hmaf_front
// Input side: takes keys from the input channel and queues them for the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hmaf_front #(
    parameter int QUEUE_DEPTH = hmaf_pkg::QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept_en,
    input  logic               s_valid,
    output logic               s_ready,
    input  hmaf_pkg::in_item_t s_data,
    output logic               q_valid,
    output hmaf_pkg::in_item_t q_item,
    input  logic               q_pop
);

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LVL_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_SLOT = PTR_BITS'(QUEUE_DEPTH - 1);
    localparam logic [LVL_BITS-1:0] FULL_LVL  = LVL_BITS'(QUEUE_DEPTH);

    hmaf_pkg::in_item_t  slots_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LVL_BITS-1:0] level_reg, level_next;
    logic                push, pop;

    assign s_ready = accept_en && (level_reg != FULL_LVL);
    assign q_valid = (level_reg != '0);
    assign q_item  = slots_reg[rd_ptr_reg];

    assign push = s_valid && s_ready;
    assign pop  = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + PTR_BITS'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + PTR_BITS'(1);
        end
        level_next = level_reg + LVL_BITS'(push) - LVL_BITS'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= s_data;
        end
    end

endmodule

// File: design/hmaf_back.sv
// ----------------------------------------------------------------------------
// hmaf_back
// Histogram engine: counts keys in a bin RAM, scans it on the last key of a
// set, clears each bin as it is scanned, and holds the result for transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hmaf_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  hmaf_pkg::in_item_t  q_item,
    output logic                q_pop,
    output logic                accept_en,
    output logic                m_valid,
    input  logic                m_ready,
    output hmaf_pkg::out_item_t m_data
);

    localparam int KB = hmaf_pkg::KEY_BITS;
    localparam int CB = hmaf_pkg::COUNT_BITS;
    localparam logic [KB-1:0] SIGN_FLIP = {1'b1, {(KB-1){1'b0}}};

    hmaf_pkg::back_state_t state_reg, state_next;

    logic [KB:0]   idx_reg, idx_next;
    logic          b_valid_reg, b_valid_next;
    logic [KB-1:0] b_key_reg, b_key_next;
    logic          b_last_reg, b_last_next;
    logic          fwd_valid_reg, fwd_valid_next;
    logic [KB-1:0] fwd_key_reg, fwd_key_next;
    logic [CB-1:0] fwd_cnt_reg, fwd_cnt_next;
    logic          sat_reg, sat_next;
    logic          sc_valid_reg, sc_valid_next;
    logic [KB-1:0] sc_idx_reg, sc_idx_next;
    logic [CB-1:0] top_reg, top_next;
    logic [KB-1:0] top_s_reg, top_s_next, top_l_reg, top_l_next;
    logic [CB-1:0] low_reg, low_next;
    logic [KB-1:0] low_s_reg, low_s_next, low_l_reg, low_l_next;
    logic          low_valid_reg, low_valid_next;
    logic          out_valid_reg, out_valid_next;
    hmaf_pkg::out_item_t out_reg, out_next;

    logic          wr_en, rd_en;
    logic [KB-1:0] wr_addr, rd_addr;
    logic [CB-1:0] wr_data, rd_data;
    logic [CB-1:0] cnt_old, cnt_new;

    hmaf_ram #(
        .DATA_BITS(CB),
        .ADDR_BITS(KB)
    ) u_bins (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // The bin written in the previous cycle was read before that write landed,
    // so a back-to-back repeat of the same key takes the forwarded count.
    assign cnt_old = (fwd_valid_reg && (fwd_key_reg == b_key_reg)) ? fwd_cnt_reg : rd_data;
    assign cnt_new = (cnt_old == hmaf_pkg::COUNT_MAX) ? cnt_old : cnt_old + CB'(1);

    assign accept_en = (state_reg != hmaf_pkg::ST_CLEAR);
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        b_valid_next   = 1'b0;
        b_key_next     = b_key_reg;
        b_last_next    = b_last_reg;
        fwd_valid_next = 1'b0;
        fwd_key_next   = fwd_key_reg;
        fwd_cnt_next   = fwd_cnt_reg;
        sat_next       = sat_reg;
        sc_valid_next  = 1'b0;
        sc_idx_next    = sc_idx_reg;
        top_next       = top_reg;
        top_s_next     = top_s_reg;
        top_l_next     = top_l_reg;
        low_next       = low_reg;
        low_s_next     = low_s_reg;
        low_l_next     = low_l_reg;
        low_valid_next = low_valid_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        q_pop          = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = b_key_reg;
        wr_data        = '0;
        rd_en          = 1'b0;
        rd_addr        = q_item.key_value;

        unique case (state_reg)
            hmaf_pkg::ST_CLEAR: begin
                wr_en    = 1'b1;
                wr_addr  = idx_reg[KB-1:0];
                idx_next = idx_reg + (KB+1)'(1);
                if (idx_reg[KB-1:0] == {KB{1'b1}}) begin
                    idx_next   = '0;
                    state_next = hmaf_pkg::ST_COUNT;
                end
            end

            hmaf_pkg::ST_COUNT: begin
                // Hold further keys once the last key of a set is in flight.
                q_pop        = q_valid && !(b_valid_reg && b_last_reg);
                rd_en        = q_pop;
                b_valid_next = q_pop;
                if (q_pop) begin
                    b_key_next  = q_item.key_value;
                    b_last_next = q_item.is_last;
                end
                if (b_valid_reg) begin
                    wr_en          = 1'b1;
                    wr_addr        = b_key_reg;
                    wr_data        = cnt_new;
                    fwd_valid_next = 1'b1;
                    fwd_key_next   = b_key_reg;
                    fwd_cnt_next   = cnt_new;
                    if (cnt_new == hmaf_pkg::COUNT_MAX) begin
                        sat_next = 1'b1;
                    end
                    if (b_last_reg) begin
                        state_next     = hmaf_pkg::ST_SCAN;
                        idx_next       = '0;
                        top_next       = '0;
                        low_valid_next = 1'b0;
                    end
                end
            end

            hmaf_pkg::ST_SCAN: begin
                // Flipping the sign bit visits the bins in ascending signed order.
                if (!idx_reg[KB]) begin
                    rd_en         = 1'b1;
                    rd_addr       = idx_reg[KB-1:0] ^ SIGN_FLIP;
                    idx_next      = idx_reg + (KB+1)'(1);
                    sc_valid_next = 1'b1;
                    sc_idx_next   = idx_reg[KB-1:0] ^ SIGN_FLIP;
                end
                if (sc_valid_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = sc_idx_reg;
                    wr_data = '0;
                    if (rd_data != '0) begin
                        if (rd_data > top_reg) begin
                            top_next   = rd_data;
                            top_s_next = sc_idx_reg;
                            top_l_next = sc_idx_reg;
                        end else if (rd_data == top_reg) begin
                            top_l_next = sc_idx_reg;
                        end
                        if (!low_valid_reg || (rd_data < low_reg)) begin
                            low_next       = rd_data;
                            low_s_next     = sc_idx_reg;
                            low_l_next     = sc_idx_reg;
                            low_valid_next = 1'b1;
                        end else if (rd_data == low_reg) begin
                            low_l_next = sc_idx_reg;
                        end
                    end
                end
                // The result waits here until the output register is free.
                if (idx_reg[KB] && !sc_valid_reg && (!out_valid_reg || m_ready)) begin
                    out_valid_next           = 1'b1;
                    out_next.top_count       = top_reg;
                    out_next.top_key_small   = top_s_reg;
                    out_next.top_key_large   = top_l_reg;
                    out_next.low_count       = low_reg;
                    out_next.low_key_small   = low_s_reg;
                    out_next.low_key_large   = low_l_reg;
                    out_next.count_saturated = sat_reg;
                    sat_next                 = 1'b0;
                    idx_next                 = '0;
                    state_next               = hmaf_pkg::ST_COUNT;
                end
            end

            default: begin
                state_next = hmaf_pkg::ST_CLEAR;
                idx_next   = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= hmaf_pkg::ST_CLEAR;
            idx_reg       <= '0;
            b_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
            sat_reg       <= 1'b0;
            sc_valid_reg  <= 1'b0;
            low_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            b_valid_reg   <= b_valid_next;
            fwd_valid_reg <= fwd_valid_next;
            sat_reg       <= sat_next;
            sc_valid_reg  <= sc_valid_next;
            low_valid_reg <= low_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        b_key_reg   <= b_key_next;
        b_last_reg  <= b_last_next;
        fwd_key_reg <= fwd_key_next;
        fwd_cnt_reg <= fwd_cnt_next;
        sc_idx_reg  <= sc_idx_next;
        top_reg     <= top_next;
        top_s_reg   <= top_s_next;
        top_l_reg   <= top_l_next;
        low_reg     <= low_next;
        low_s_reg   <= low_s_next;
        low_l_reg   <= low_l_next;
        out_reg     <= out_next;
    end

endmodule

// File: design/histogram_mode_antimode_finder.sv
// ----------------------------------------------------------------------------
// histogram_mode_antimode_finder
// Counts signed keys in a histogram and, on the last key of a set, reports the
// most and the least frequent counts with their smallest and largest keys.
//
//   Channel | Direction | Handshake          | Payload
//   s_      | in        | s_valid / s_ready  | hmaf_pkg::in_item_t  (one key)
//   m_      | out       | m_valid / m_ready  | hmaf_pkg::out_item_t (one per set)
//
// A key that is not last is counted at one per cycle through the bin RAM while the back is counting.
// A last key adds a scan of the bin RAM, one bin per cycle.
// After reset the bin RAM is cleared one bin per cycle, during which s_ready
// is low.
// Keys queue in the front while the back scans or a result awaits transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module histogram_mode_antimode_finder #(
    parameter int QUEUE_DEPTH = hmaf_pkg::QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  hmaf_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output hmaf_pkg::out_item_t m_data
);

    logic               q_valid;
    logic               q_pop;
    logic               accept_en;
    hmaf_pkg::in_item_t q_item;

    hmaf_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept_en(accept_en),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    hmaf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .accept_en(accept_en),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    `HMAF_ASSERT_IMP(a_counts_ordered, aclk, aresetn, m_valid, (m_data.low_count != '0) && (m_data.low_count <= m_data.top_count))
    `HMAF_ASSERT_IMP(a_top_keys_ordered, aclk, aresetn, m_valid, $signed(m_data.top_key_small) <= $signed(m_data.top_key_large))
    `HMAF_ASSERT_IMP(a_low_keys_ordered, aclk, aresetn, m_valid, $signed(m_data.low_key_small) <= $signed(m_data.low_key_large))
    `HMAF_ASSERT_NXT(a_no_result_in_clear, aclk, aresetn, !accept_en, !m_valid)

endmodule
